[sv/gtr_pkg.sv]
// Shared constants, widths and controller/datapath interface types for the glyph text renderer.
package gtr_pkg;

  localparam int GLYPH_COUNT   = 256;
  localparam int SCREEN_WIDTH  = 400;
  localparam int SCREEN_HEIGHT = 240;
  localparam int CHAR_STEP_X   = 8;
  localparam int LINE_STEP_Y   = 10;

  localparam int GLYPH_ROWS = 8;
  localparam int GLYPH_COLS = 8;
  localparam int GLYPH_PIX  = GLYPH_ROWS * GLYPH_COLS;

  localparam int OP_W   = 2;
  localparam int GI_IN_W = 8;
  localparam int ROW_W  = 3;
  localparam int BITS_W = 8;
  localparam int SX_W   = 9;
  localparam int SY_W   = 8;
  localparam int COLOR_W = 24;
  localparam int CHAR_W = 8;
  localparam int OFS_W  = 19;
  localparam int LINE_W = 10;
  localparam int COL_W  = 7;

  localparam int GI_W     = $clog2(GLYPH_COUNT);
  localparam int GS_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
  localparam int GS_AW    = $clog2(GS_DEPTH);
  localparam int XW       = $clog2((2 ** SX_W) + 128 * CHAR_STEP_X);
  localparam int CNT_W    = $clog2(GLYPH_PIX);

  localparam logic [COL_W-1:0]  COL_MAX  = '1;
  localparam logic [LINE_W-1:0] LINE_MAX = '1;

  localparam logic [OP_W-1:0] OP_GLYPH = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_CHAR  = 2'd2;

  localparam logic [CHAR_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CODE_SPACE   = 8'd32;

  typedef struct packed {
    logic glyph_wr;
    logic start_str;
    logic char_latch;
    logic plan;
    logic setup;
    logic cnt_clr;
    logic load_step;
    logic scan_step;
    logic emit;
  } gtr_cmd_t;

  typedef struct packed {
    logic skip_draw;
    logic load_done;
    logic scan_last;
    logic pix_hit;
    logic out_free;
  } gtr_sts_t;

endpackage

[sv/gtr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module gtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/gtr_ctrl.sv]
// Controller state machine for the glyph text renderer.
module gtr_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [gtr_pkg::OP_W-1:0] in_opcode,
  input  gtr_pkg::gtr_sts_t        sts,
  output gtr_pkg::gtr_cmd_t        cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLAN,
    S_SETUP,
    S_LOAD,
    S_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_opcode)
            gtr_pkg::OP_GLYPH: cmd.glyph_wr = 1'b1;
            gtr_pkg::OP_START: cmd.start_str = 1'b1;
            gtr_pkg::OP_CHAR: begin
              cmd.char_latch = 1'b1;
              state_nxt      = S_PLAN;
            end
            default: ;
          endcase
        end
      end
      S_PLAN: begin
        cmd.plan  = 1'b1;
        state_nxt = sts.skip_draw ? S_IDLE : S_SETUP;
      end
      S_SETUP: begin
        cmd.setup   = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_step = 1'b1;
        if (sts.load_done) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.pix_hit || sts.out_free) begin
          cmd.scan_step = 1'b1;
          cmd.emit      = sts.pix_hit;
          if (sts.scan_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[sv/gtr_dp.sv]
// Datapath: text position state, glyph store, pixel mask, offset walk and output register.
module gtr_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gtr_pkg::gtr_cmd_t            cmd,
  output gtr_pkg::gtr_sts_t            sts,
  input  logic [gtr_pkg::GI_IN_W-1:0]  in_glyph_index,
  input  logic [gtr_pkg::ROW_W-1:0]    in_glyph_row,
  input  logic [gtr_pkg::BITS_W-1:0]   in_glyph_bits,
  input  logic [gtr_pkg::SX_W-1:0]     in_start_x,
  input  logic [gtr_pkg::SY_W-1:0]     in_start_y,
  input  logic [gtr_pkg::COLOR_W-1:0]  in_ink_color,
  input  logic [gtr_pkg::CHAR_W-1:0]   in_char_code,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gtr_pkg::OFS_W-1:0]    out_pixel_offset,
  output logic [gtr_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic                         out_last_pixel,
  output logic [gtr_pkg::LINE_W-1:0]   out_line_position
);

  localparam int XW    = gtr_pkg::XW;
  localparam int OFS_W = gtr_pkg::OFS_W;

  logic [gtr_pkg::COL_W-1:0]   col_r;
  logic [gtr_pkg::LINE_W-1:0]  line_r;
  logic [gtr_pkg::SX_W-1:0]    origin_r;
  logic [gtr_pkg::COLOR_W-1:0] color_r;
  logic                        started_r;
  logic [gtr_pkg::CHAR_W-1:0]  ch_r;
  logic [XW-1:0]               x0_r;
  logic [gtr_pkg::LINE_W-1:0]  y0_r;
  logic [OFS_W-1:0]            prod_r;
  logic [OFS_W-1:0]            acc_r;
  logic [gtr_pkg::CNT_W-1:0]   cnt_r;
  logic [gtr_pkg::GLYPH_PIX-1:0] rem_r;

  logic                        out_valid_r;
  logic [OFS_W-1:0]            ofs_r;
  logic                        last_r;
  logic [gtr_pkg::LINE_W-1:0]  pos_r;
  logic [gtr_pkg::COLOR_W-1:0] pcol_r;

  logic [XW-1:0]                 x0_cur;
  logic [XW-1:0]                 x0_wrap;
  logic                          wrap;
  logic                          is_nl;
  logic                          is_sp;
  logic                          no_glyph;
  logic [gtr_pkg::LINE_W:0]      line_sum;
  logic [gtr_pkg::LINE_W-1:0]    line_adv;
  logic [gtr_pkg::GLYPH_COLS-1:0] col_ok;
  logic                          row_ok;
  logic [gtr_pkg::ROW_W-1:0]     cap_row;
  logic [gtr_pkg::BITS_W-1:0]    rd_bits;
  logic [gtr_pkg::GLYPH_COLS-1:0] cap_bits;
  logic                          gs_we;
  logic [gtr_pkg::GS_AW-1:0]     gs_waddr;
  logic [gtr_pkg::GS_AW-1:0]     gs_raddr;
  logic                          out_free;

  // glyph store
  assign gs_we    = cmd.glyph_wr &&
                    ({1'b0, in_glyph_index} < (gtr_pkg::GI_IN_W + 1)'(gtr_pkg::GLYPH_COUNT));
  assign gs_waddr = gtr_pkg::GS_AW'({in_glyph_index[gtr_pkg::GI_W-1:0], in_glyph_row});
  assign gs_raddr = gtr_pkg::GS_AW'({ch_r[gtr_pkg::GI_W-1:0], cnt_r[gtr_pkg::ROW_W-1:0]});

  gtr_ram #(
    .WIDTH (gtr_pkg::BITS_W),
    .DEPTH (gtr_pkg::GS_DEPTH)
  ) u_glyph_store (
    .clk   (clk),
    .we    (gs_we),
    .waddr (gs_waddr),
    .wdata (in_glyph_bits),
    .raddr (gs_raddr),
    .rdata (rd_bits)
  );

  // character placement; wrap limit is zero until the first string start
  assign x0_cur   = XW'(origin_r) + XW'(col_r * gtr_pkg::CHAR_STEP_X);
  assign x0_wrap  = XW'(origin_r) + XW'(2 * gtr_pkg::CHAR_STEP_X);
  assign wrap     = !started_r || (col_r == gtr_pkg::COL_MAX) ||
                    ((x0_cur + XW'(gtr_pkg::CHAR_STEP_X)) > XW'(gtr_pkg::SCREEN_WIDTH));
  assign is_nl    = (ch_r == gtr_pkg::CODE_NEWLINE);
  assign is_sp    = (ch_r == gtr_pkg::CODE_SPACE);
  assign no_glyph = ({1'b0, ch_r} >= (gtr_pkg::CHAR_W + 1)'(gtr_pkg::GLYPH_COUNT));
  assign line_sum = {1'b0, line_r} + (gtr_pkg::LINE_W + 1)'(gtr_pkg::LINE_STEP_Y);
  assign line_adv = (line_sum > {1'b0, gtr_pkg::LINE_MAX}) ? gtr_pkg::LINE_MAX
                                                           : line_sum[gtr_pkg::LINE_W-1:0];

  // on-screen tests for glyph cells
  always_comb begin
    for (int b = 0; b < gtr_pkg::GLYPH_COLS; b++) begin
      col_ok[b] = (x0_r + XW'(b)) < XW'(gtr_pkg::SCREEN_WIDTH);
    end
  end

  assign cap_row = gtr_pkg::ROW_W'(cnt_r - gtr_pkg::CNT_W'(1));
  assign row_ok  = ({1'b0, y0_r} + (gtr_pkg::LINE_W + 1)'(cap_row)) <
                   (gtr_pkg::LINE_W + 1)'(gtr_pkg::SCREEN_HEIGHT);

  always_comb begin
    for (int b = 0; b < gtr_pkg::GLYPH_COLS; b++) begin
      cap_bits[b] = rd_bits[gtr_pkg::BITS_W-1-b] && col_ok[b] && row_ok;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  assign sts.skip_draw = is_nl || (wrap && is_sp) || no_glyph;
  assign sts.load_done = (cnt_r == gtr_pkg::CNT_W'(gtr_pkg::GLYPH_ROWS));
  assign sts.scan_last = (cnt_r == gtr_pkg::CNT_W'(gtr_pkg::GLYPH_PIX - 1));
  assign sts.pix_hit   = rem_r[0];
  assign sts.out_free  = out_free;

  // text position state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      line_r    <= '0;
      origin_r  <= '0;
      color_r   <= '0;
      started_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      if (cmd.start_str) begin
        origin_r  <= in_start_x;
        line_r    <= gtr_pkg::LINE_W'(in_start_y);
        color_r   <= in_ink_color;
        col_r     <= '0;
        started_r <= 1'b1;
      end
      if (cmd.plan) begin
        if (is_nl) begin
          line_r <= line_adv;
          col_r  <= '0;
        end else if (wrap) begin
          line_r <= line_adv;
          col_r  <= is_sp ? gtr_pkg::COL_W'(2) : gtr_pkg::COL_W'(3);
        end else if (col_r != gtr_pkg::COL_MAX) begin
          col_r <= col_r + gtr_pkg::COL_W'(1);
        end
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.load_step || cmd.scan_step) begin
        cnt_r <= cnt_r + gtr_pkg::CNT_W'(1);
      end
    end
  end

  // per-character working registers
  always_ff @(posedge clk) begin
    if (cmd.char_latch) begin
      ch_r <= in_char_code;
    end
    if (cmd.plan) begin
      x0_r <= wrap ? x0_wrap : x0_cur;
      y0_r <= wrap ? line_adv : line_r;
    end
    if (cmd.setup) begin
      prod_r <= OFS_W'(x0_r) * OFS_W'(gtr_pkg::SCREEN_HEIGHT);
    end
    if (cmd.load_step) begin
      if (cnt_r == '0) begin
        acc_r <= prod_r + OFS_W'(gtr_pkg::SCREEN_HEIGHT - 1) - OFS_W'(y0_r);
      end else begin
        for (int k = 0; k < gtr_pkg::GLYPH_ROWS; k++) begin
          if (cap_row == gtr_pkg::ROW_W'(k)) begin
            rem_r[k*gtr_pkg::GLYPH_COLS +: gtr_pkg::GLYPH_COLS] <= cap_bits;
          end
        end
      end
    end
    if (cmd.scan_step) begin
      rem_r <= rem_r >> 1;
      if (cnt_r[gtr_pkg::ROW_W-1:0] == gtr_pkg::ROW_W'(gtr_pkg::GLYPH_COLS - 1)) begin
        acc_r <= acc_r - OFS_W'((gtr_pkg::GLYPH_COLS - 1) * gtr_pkg::SCREEN_HEIGHT + 1);
      end else begin
        acc_r <= acc_r + OFS_W'(gtr_pkg::SCREEN_HEIGHT);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ofs_r  <= {acc_r[OFS_W-2:0], 1'b0} + acc_r;
      pcol_r <= color_r;
      last_r <= (rem_r[gtr_pkg::GLYPH_PIX-1:1] == '0);
      pos_r  <= y0_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_offset  = ofs_r;
  assign out_pixel_color   = pcol_r;
  assign out_last_pixel    = last_r;
  assign out_line_position = pos_r;

endmodule

[sv/glyph_text_renderer.sv]
// Top level of the 8x8 bitmap-font text renderer for a rotated framebuffer.
// Glyph row writes, string starts and unused opcodes are handled in idle; a newline,
// a dropped wrap space or a code without a glyph passes through the plan state only.
// A drawn character runs plan, offset multiply and glyph store reads, then one pixel
// test per cycle over 64 cells, held while a set pixel waits for the output register.
// Synchronous active-low reset clears position, color and control; the glyph store is not cleared.
module glyph_text_renderer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [gtr_pkg::OP_W-1:0]     in_opcode,
  input  logic [gtr_pkg::GI_IN_W-1:0]  in_glyph_index,
  input  logic [gtr_pkg::ROW_W-1:0]    in_glyph_row,
  input  logic [gtr_pkg::BITS_W-1:0]   in_glyph_bits,
  input  logic [gtr_pkg::SX_W-1:0]     in_start_x,
  input  logic [gtr_pkg::SY_W-1:0]     in_start_y,
  input  logic [gtr_pkg::COLOR_W-1:0]  in_ink_color,
  input  logic [gtr_pkg::CHAR_W-1:0]   in_char_code,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [gtr_pkg::OFS_W-1:0]    out_pixel_offset,
  output logic [gtr_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic                         out_last_pixel,
  output logic [gtr_pkg::LINE_W-1:0]   out_line_position
);

  gtr_pkg::gtr_cmd_t cmd;
  gtr_pkg::gtr_sts_t sts;

  gtr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .sts       (sts),
    .cmd       (cmd)
  );

  gtr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_glyph_index    (in_glyph_index),
    .in_glyph_row      (in_glyph_row),
    .in_glyph_bits     (in_glyph_bits),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_ink_color      (in_ink_color),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_offset  (out_pixel_offset),
    .out_pixel_color   (out_pixel_color),
    .out_last_pixel    (out_last_pixel),
    .out_line_position (out_line_position)
  );

endmodule

[dv/glyph_text_renderer_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for glyph_text_renderer: glyph loads, strings and characters vs. a pixel predictor.
module glyph_text_renderer_tb;

  localparam logic [gtr_pkg::OP_W-1:0] OP_NONE = 2'd3;
  localparam int ITEM_TARGET = 380;
  localparam int DRAIN_TAIL  = 90;

  typedef struct packed {
    logic [gtr_pkg::OP_W-1:0]    op;
    logic [gtr_pkg::GI_IN_W-1:0] glyph_index;
    logic [gtr_pkg::ROW_W-1:0]   glyph_row;
    logic [gtr_pkg::BITS_W-1:0]  glyph_bits;
    logic [gtr_pkg::SX_W-1:0]    start_x;
    logic [gtr_pkg::SY_W-1:0]    start_y;
    logic [gtr_pkg::COLOR_W-1:0] ink;
    logic [gtr_pkg::CHAR_W-1:0]  char_code;
  } text_item_t;

  typedef struct packed {
    logic [gtr_pkg::OFS_W-1:0]   offset;
    logic [gtr_pkg::COLOR_W-1:0] color;
    logic                        last;
    logic [gtr_pkg::LINE_W-1:0]  line_pos;
  } pixel_t;

  class glyph_pixel_tracker;
    logic [gtr_pkg::BITS_W-1:0] font_rows [gtr_pkg::GS_DEPTH];
    int unsigned col;
    int unsigned line_top;
    int unsigned origin_x;
    int unsigned wrap_cols;
    logic [gtr_pkg::COLOR_W-1:0] ink;
    pixel_t pending[$];
    int errors;

    function void clear_position();
      col = 0;
      line_top = 0;
      origin_x = 0;
      wrap_cols = 0;
      ink = '0;
      errors = 0;
    endfunction

    function void next_line();
      line_top = (line_top + gtr_pkg::LINE_STEP_Y > gtr_pkg::LINE_MAX) ?
                 32'(gtr_pkg::LINE_MAX) : line_top + gtr_pkg::LINE_STEP_Y;
    endfunction

    function void take_item(text_item_t it);
      int unsigned x0, y0, px, py;
      int r, b, first;
      pixel_t p;
      first = pending.size();
      case (it.op)
        gtr_pkg::OP_GLYPH:
          font_rows[it.glyph_index * gtr_pkg::GLYPH_ROWS + it.glyph_row] = it.glyph_bits;
        gtr_pkg::OP_START: begin
          origin_x = 32'(it.start_x);
          line_top = 32'(it.start_y);
          ink = it.ink;
          col = 0;
          wrap_cols = (it.start_x < gtr_pkg::SCREEN_WIDTH) ?
                      (gtr_pkg::SCREEN_WIDTH - it.start_x) / gtr_pkg::CHAR_STEP_X : 0;
          if (wrap_cols > gtr_pkg::COL_MAX) wrap_cols = 32'(gtr_pkg::COL_MAX);
        end
        gtr_pkg::OP_CHAR: begin
          if (it.char_code == gtr_pkg::CODE_NEWLINE) begin
            next_line();
            col = 0;
            return;
          end
          if (col >= wrap_cols) begin
            next_line();
            col = 2;
            if (it.char_code == gtr_pkg::CODE_SPACE) return;
          end
          x0 = origin_x + col * gtr_pkg::CHAR_STEP_X;
          y0 = line_top;
          if (col < gtr_pkg::COL_MAX) col++;
          for (r = 0; r < gtr_pkg::GLYPH_ROWS; r++) begin
            for (b = 0; b < gtr_pkg::GLYPH_COLS; b++) begin
              py = y0 + r;
              px = x0 + b;
              if (font_rows[it.char_code * gtr_pkg::GLYPH_ROWS + r][7 - b] &&
                  px < gtr_pkg::SCREEN_WIDTH && py < gtr_pkg::SCREEN_HEIGHT) begin
                p.offset   = gtr_pkg::OFS_W'((px * gtr_pkg::SCREEN_HEIGHT +
                                              gtr_pkg::SCREEN_HEIGHT - 1 - py) * 3);
                p.color    = ink;
                p.last     = 1'b0;
                p.line_pos = gtr_pkg::LINE_W'(y0);
                pending.push_back(p);
              end
            end
          end
          if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void match_pixel(logic [gtr_pkg::OFS_W-1:0] offset,
                              logic [gtr_pkg::COLOR_W-1:0] color,
                              logic last, logic [gtr_pkg::LINE_W-1:0] line_pos);
      pixel_t e;
      if (pending.size() == 0) begin
        $error("unexpected pixel transfer: offset %0d", offset);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (offset !== e.offset) begin
        $error("pixel_offset: expected %0d, got %0d", e.offset, offset);
        errors++;
      end
      if (color !== e.color) begin
        $error("pixel_color: expected %06h, got %06h", e.color, color);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_pixel: expected %0d, got %0d", e.last, last);
        errors++;
      end
      if (line_pos !== e.line_pos) begin
        $error("line_position: expected %0d, got %0d", e.line_pos, line_pos);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [gtr_pkg::OP_W-1:0]      in_opcode;
  logic [gtr_pkg::GI_IN_W-1:0]   in_glyph_index;
  logic [gtr_pkg::ROW_W-1:0]     in_glyph_row;
  logic [gtr_pkg::BITS_W-1:0]    in_glyph_bits;
  logic [gtr_pkg::SX_W-1:0]      in_start_x;
  logic [gtr_pkg::SY_W-1:0]      in_start_y;
  logic [gtr_pkg::COLOR_W-1:0]   in_ink_color;
  logic [gtr_pkg::CHAR_W-1:0]    in_char_code;
  logic                          out_valid;
  logic                          out_ready;
  logic [gtr_pkg::OFS_W-1:0]     out_pixel_offset;
  logic [gtr_pkg::COLOR_W-1:0]   out_pixel_color;
  logic                          out_last_pixel;
  logic [gtr_pkg::LINE_W-1:0]    out_line_position;

  glyph_pixel_tracker pixels;
  byte unsigned drawable[$];
  int sent;
  bit calm;

  glyph_text_renderer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_glyph_index    (in_glyph_index),
    .in_glyph_row      (in_glyph_row),
    .in_glyph_bits     (in_glyph_bits),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_ink_color      (in_ink_color),
    .in_char_code      (in_char_code),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_offset  (out_pixel_offset),
    .out_pixel_color   (out_pixel_color),
    .out_last_pixel    (out_last_pixel),
    .out_line_position (out_line_position)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic text_item_t any_item();
    text_item_t it;
    it.op          = OP_NONE;
    it.glyph_index = gtr_pkg::GI_IN_W'($urandom);
    it.glyph_row   = gtr_pkg::ROW_W'($urandom);
    it.glyph_bits  = gtr_pkg::BITS_W'($urandom);
    it.start_x     = gtr_pkg::SX_W'($urandom);
    it.start_y     = gtr_pkg::SY_W'($urandom);
    it.ink         = gtr_pkg::COLOR_W'($urandom);
    it.char_code   = gtr_pkg::CHAR_W'($urandom);
    return it;
  endfunction

  initial begin
    int n;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      pixels.match_pixel(out_pixel_offset, out_pixel_color, out_last_pixel, out_line_position);
  end

  task automatic send_item(input text_item_t it);
    in_valid       <= 1'b1;
    in_opcode      <= it.op;
    in_glyph_index <= it.glyph_index;
    in_glyph_row   <= it.glyph_row;
    in_glyph_bits  <= it.glyph_bits;
    in_start_x     <= it.start_x;
    in_start_y     <= it.start_y;
    in_ink_color   <= it.ink;
    in_char_code   <= it.char_code;
    do @(posedge clk); while (!in_ready);
    pixels.take_item(it);
    sent++;
  endtask

  task automatic pause(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic next_gap();
    if (!calm) pause(gap_len());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pixels.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic load_glyph(input int code, input logic [63:0] rows);
    text_item_t it;
    bit known;
    for (int r = 0; r < gtr_pkg::GLYPH_ROWS; r++) begin
      it = any_item();
      it.op          = gtr_pkg::OP_GLYPH;
      it.glyph_index = gtr_pkg::GI_IN_W'(code);
      it.glyph_row   = gtr_pkg::ROW_W'(r);
      it.glyph_bits  = rows[63 - 8 * r -: 8];
      send_item(it);
      next_gap();
    end
    known = 0;
    foreach (drawable[i]) if (drawable[i] == code) known = 1;
    if (!known) drawable.push_back(8'(code));
  endtask

  task automatic start_string(input int sx, input int sy,
                              input logic [gtr_pkg::COLOR_W-1:0] ink);
    text_item_t it;
    it = any_item();
    it.op      = gtr_pkg::OP_START;
    it.start_x = gtr_pkg::SX_W'(sx);
    it.start_y = gtr_pkg::SY_W'(sy);
    it.ink     = ink;
    send_item(it);
    next_gap();
  endtask

  task automatic put_char(input int code);
    text_item_t it;
    it = any_item();
    it.op        = gtr_pkg::OP_CHAR;
    it.char_code = gtr_pkg::CHAR_W'(code);
    send_item(it);
    next_gap();
  endtask

  task automatic put_noise();
    text_item_t it;
    it = any_item();
    if ($urandom_range(0, 1)) it.op = gtr_pkg::OP_GLYPH;
    send_item(it);
    next_gap();
  endtask

  task automatic put_text_char();
    int c;
    c = $urandom_range(0, 99);
    if (c < 72) put_char(drawable[$urandom_range(0, drawable.size() - 1)]);
    else if (c < 84) put_char(gtr_pkg::CODE_NEWLINE);
    else if (c < 94) put_char(gtr_pkg::CODE_SPACE);
    else put_noise();
  endtask

  initial begin
    int roll, len;
    bit deep_done;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = '0;
    in_glyph_index = '0;
    in_glyph_row   = '0;
    in_glyph_bits  = '0;
    in_start_x     = '0;
    in_start_y     = '0;
    in_ink_color   = '0;
    in_char_code   = '0;
    sent      = 0;
    calm      = 1;
    deep_done = 0;
    pixels = new;
    pixels.clear_position();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: character before any string start, full/edge bit patterns, empty glyph,
    // newline, wrap with clipping
    load_glyph(255, 64'hFF80_01AA_5500_FF81);
    load_glyph(gtr_pkg::CODE_SPACE, 64'h0);
    put_char(255);
    start_string(0, 0, 24'hFFFFFF);
    put_char(255);
    put_char(gtr_pkg::CODE_SPACE);
    put_char(gtr_pkg::CODE_NEWLINE);
    put_char(255);
    put_noise();
    start_string(380, 226, 24'hA5_5A_3C);
    put_char(255);
    put_char(255);
    put_char(255);
    put_char(gtr_pkg::CODE_SPACE);
    settle();

    while (sent < ITEM_TARGET) begin
      calm = ($urandom_range(0, 3) == 0);
      roll = $urandom_range(0, 99);
      if (drawable.size() < 4 || roll < 18) begin
        load_glyph($urandom_range(0, 255),
                   ($urandom_range(0, 9) == 0) ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
      end else if (roll < 24) begin
        put_noise();
      end else if (!deep_done && sent > 150) begin
        // long descent: line position must saturate, never wrap back on screen
        deep_done = 1;
        start_string($urandom_range(0, 511), 255, gtr_pkg::COLOR_W'($urandom));
        repeat (90) begin
          if ($urandom_range(0, 1)) put_char(gtr_pkg::CODE_NEWLINE);
          else put_char(drawable[$urandom_range(0, drawable.size() - 1)]);
        end
      end else begin
        start_string(($urandom_range(0, 9) == 0) ? $urandom_range(380, 511) :
                                                    $urandom_range(0, 399),
                     ($urandom_range(0, 9) == 0) ? $urandom_range(220, 255) :
                                                    $urandom_range(0, 239),
                     gtr_pkg::COLOR_W'($urandom));
        len = $urandom_range(1, 24);
        repeat (len) put_text_char();
      end
      if ($urandom_range(0, 9) == 0) settle();
    end

    settle();
    if (pixels.errors == 0 && pixels.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
